// ----- rtl/tpvc_pkg.sv -----
// Shared types, register indexes and constants of the three-point valve controller.
// No dependencies; used by tpvc_step and three_point_valve_controller.
package tpvc_pkg;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int TEMP_W   = 12;
    localparam int POS_W    = 20;
    localparam int BAND_W   = 11;
    localparam int DELAY_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 3'd5;

    // Register reset values
    localparam logic [POS_W-1:0]   TRAVEL_RESET = 20'd60000;
    localparam logic [TEMP_W-1:0]  TARGET_RESET = 12'd640;
    localparam logic [BAND_W-1:0]  BAND_RESET   = 11'd16;
    localparam logic [TEMP_W-1:0]  ALARM_RESET  = 12'd1280;
    localparam logic [DELAY_W-1:0] SETTLE_RESET = 24'd60000;
    localparam logic [DELAY_W-1:0] PULSE_RESET  = 24'd5000;

    // Reported mode codes
    localparam logic [1:0] MODE_HOLD    = 2'd0;
    localparam logic [1:0] MODE_CLOSING = 2'd1;
    localparam logic [1:0] MODE_OPENING = 2'd2;
    localparam logic [1:0] MODE_HOMING  = 2'd3;

    // Pin pair: bit 0 open pin level, bit 1 close pin level (active low)
    localparam logic [1:0] PINS_HOLD  = 2'b11;
    localparam logic [1:0] PINS_CLOSE = 2'b01;
    localparam logic [1:0] PINS_OPEN  = 2'b10;

    typedef enum logic [3:0] {
        ST_HOLD    = 4'b0001,
        ST_CLOSING = 4'b0010,
        ST_OPENING = 4'b0100,
        ST_HOMING  = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        ctrl_state_t         mode;
        logic [1:0]          pins;
        logic [POS_W-1:0]    pos;
        logic [TICK_W-1:0]   last_tick;
        logic [TICK_W-1:0]   last_change;
    } tpvc_state_t;

    typedef struct packed {
        logic [POS_W-1:0]    travel_time;
        logic [TEMP_W-1:0]   target_temp;
        logic [BAND_W-1:0]   band_half;
        logic [TEMP_W-1:0]   alarm_temp;
        logic [DELAY_W-1:0]  settle;
        logic [DELAY_W-1:0]  pulse;
    } tpvc_cfg_t;

    function automatic logic [1:0] mode_code(input ctrl_state_t st);
        logic [1:0] code;
        case (st)
            ST_HOLD:    code = MODE_HOLD;
            ST_CLOSING: code = MODE_CLOSING;
            ST_OPENING: code = MODE_OPENING;
            ST_HOMING:  code = MODE_HOMING;
            default:    code = MODE_HOLD;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/tpvc_step.sv -----
// Next-state logic of the valve controller for one control cycle request.
// Depends on tpvc_pkg for the state and configuration structs.
module tpvc_step (
    input  tpvc_pkg::tpvc_cfg_t               cfg,
    input  tpvc_pkg::tpvc_state_t             cur,
    input  logic [tpvc_pkg::TICK_W-1:0]       now_ms,
    input  logic signed [tpvc_pkg::TEMP_W-1:0] temperature,
    output tpvc_pkg::tpvc_state_t             nxt
);
    import tpvc_pkg::*;

    logic [TICK_W-1:0]  elapsed;
    logic [TICK_W-1:0]  since;
    logic [TICK_W:0]    pos_sum;
    logic [POS_W-1:0]   pos_dec;
    logic [TICK_W:0]    pos_mv;
    logic [POS_W-1:0]   pos_new;
    logic [TICK_W+2:0]  since_x5;
    logic [POS_W+2:0]   travel_x6;
    logic               alarm;
    logic               home_done;
    logic signed [TEMP_W:0] err;
    logic [TEMP_W:0]    mag;
    logic               outside_band;
    logic               settled;
    logic               pulse_over;

    // Elapsed and settle times, both wrap with the timestamp
    assign elapsed = now_ms - cur.last_tick;
    assign since   = now_ms - cur.last_change;

    // Position estimate candidates
    assign pos_sum = {{(TICK_W+1-POS_W){1'b0}}, cur.pos} + {1'b0, elapsed};
    assign pos_dec = (elapsed >= {{(TICK_W-POS_W){1'b0}}, cur.pos}) ? '0
                   : cur.pos - elapsed[POS_W-1:0];

    always_comb begin
        case (cur.mode)
            ST_CLOSING, ST_HOMING: pos_mv = {{(TICK_W+1-POS_W){1'b0}}, pos_dec};
            ST_OPENING:            pos_mv = pos_sum;
            default:               pos_mv = {{(TICK_W+1-POS_W){1'b0}}, cur.pos};
        endcase
    end

    // Clamp to the stroke in every mode
    assign pos_new = (pos_mv > {{(TICK_W+1-POS_W){1'b0}}, cfg.travel_time})
                   ? cfg.travel_time : pos_mv[POS_W-1:0];

    // Homing lasts 1.2 strokes: since * 5 > travel * 6
    assign since_x5  = {3'b000, since} + {1'b0, since, 2'b00};
    assign travel_x6 = {1'b0, cfg.travel_time, 2'b00} + {2'b00, cfg.travel_time, 1'b0};
    assign home_done = since_x5 > {{(TICK_W-POS_W){1'b0}}, travel_x6};

    assign alarm = temperature > $signed(cfg.alarm_temp);

    // Hysteresis decision; an error on the band edge stays in the band
    assign err = {temperature[TEMP_W-1], temperature}
               - {cfg.target_temp[TEMP_W-1], cfg.target_temp};
    assign mag = err[TEMP_W] ? (~err + 1'b1) : err;
    assign outside_band = mag > {2'b00, cfg.band_half};

    assign settled    = since > {{(TICK_W-DELAY_W){1'b0}}, cfg.settle};
    assign pulse_over = since > {{(TICK_W-DELAY_W){1'b0}}, cfg.pulse};

    always_comb begin
        logic done;
        nxt  = cur;
        done = 1'b0;
        if (now_ms < cur.last_tick) begin
            // Timestamp went backwards: resynchronise only
            nxt.last_tick   = now_ms;
            nxt.last_change = now_ms;
        end else begin
            nxt.last_tick = now_ms;
            nxt.pos       = pos_new;
            if (alarm) begin
                // Restart homing with a close move unless the estimate is already shut
                if (pos_new == '0) begin
                    nxt.pins = PINS_HOLD;
                end else begin
                    nxt.pins = PINS_CLOSE;
                end
                nxt.mode        = ST_HOMING;
                nxt.pos         = cfg.travel_time;
                nxt.last_change = now_ms;
                done            = 1'b1;
            end else if (cur.mode == ST_HOMING) begin
                if (home_done) begin
                    nxt.pos  = '0;
                    nxt.pins = PINS_HOLD;
                    nxt.mode = ST_HOLD;
                end else begin
                    nxt.pins = (pos_new == '0) ? PINS_HOLD : PINS_CLOSE;
                    nxt.mode = ST_HOMING;
                    done     = 1'b1;
                end
            end

            if (!done) begin
                if (settled) begin
                    if (outside_band && !err[TEMP_W]) begin
                        // Too warm: close unless already shut
                        if (nxt.pos == '0) begin
                            nxt.pins = PINS_HOLD;
                            nxt.mode = ST_HOLD;
                        end else begin
                            nxt.pins = PINS_CLOSE;
                            nxt.mode = ST_CLOSING;
                        end
                    end else if (outside_band) begin
                        // Too cold: open unless already at full travel
                        if (nxt.pos >= cfg.travel_time) begin
                            nxt.pins = PINS_HOLD;
                            nxt.mode = ST_HOLD;
                        end else begin
                            nxt.pins = PINS_OPEN;
                            nxt.mode = ST_OPENING;
                        end
                    end else begin
                        nxt.pins = PINS_HOLD;
                        nxt.mode = ST_HOLD;
                    end
                end else if (pulse_over) begin
                    // Stop a running move
                    if (nxt.mode == ST_CLOSING || nxt.mode == ST_OPENING) begin
                        nxt.pins = PINS_HOLD;
                        nxt.mode = ST_HOLD;
                    end
                end
                if (nxt.mode != cur.mode) begin
                    nxt.last_change = now_ms;
                end
            end
        end
    end

endmodule

// ----- rtl/three_point_valve_controller.sv -----
// Top level of the three-point valve controller: request handshakes, registers, state.
// Depends on tpvc_pkg and tpvc_step.
//
// Each request carries a millisecond timestamp and a temperature and yields one result
// with the two active-low actuator pin levels, the mode and the position estimate. A new
// request is taken every clock unless the result side holds off while the input register
// is full. A request is captured in the input register and its result in the result
// register, with the step logic between them. When the result side holds off, the result
// register holds and the input register holds once it is full. The step logic includes
// 32-bit compare-and-subtract paths plus a 35-bit compare for the homing time.
// Configuration writes are taken every cycle and ought only to be issued while no
// request is in flight; after reset the position estimate equals the travel time reset
// value and the block starts in homing.
module three_point_valve_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpvc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpvc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tpvc_pkg::TICK_W-1:0]         s_now_ms,
    input  logic signed [tpvc_pkg::TEMP_W-1:0]  s_temperature,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_open_pin_level,
    output logic                                m_close_pin_level,
    output logic [1:0]                          m_mode,
    output logic [tpvc_pkg::POS_W-1:0]          m_position_ms
);
    import tpvc_pkg::*;

    tpvc_cfg_t              cfg_reg;
    tpvc_state_t            state_reg;
    tpvc_state_t            state_next;
    logic                   in_valid_reg;
    logic [TICK_W-1:0]      now_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                   out_valid_reg;
    logic                   open_reg;
    logic                   close_reg;
    logic [1:0]             mode_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   advance;

    // Advance when the result register is free or being drained
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance || !in_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.travel_time <= TRAVEL_RESET;
            cfg_reg.target_temp <= TARGET_RESET;
            cfg_reg.band_half   <= BAND_RESET;
            cfg_reg.alarm_temp  <= ALARM_RESET;
            cfg_reg.settle      <= SETTLE_RESET;
            cfg_reg.pulse       <= PULSE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TRAVEL_TIME: cfg_reg.travel_time <= cfg_data[POS_W-1:0];
                REG_TARGET_TEMP: cfg_reg.target_temp <= cfg_data[TEMP_W-1:0];
                REG_BAND_HALF:   cfg_reg.band_half   <= cfg_data[BAND_W-1:0];
                REG_ALARM_TEMP:  cfg_reg.alarm_temp  <= cfg_data[TEMP_W-1:0];
                REG_SETTLE:      cfg_reg.settle      <= cfg_data[DELAY_W-1:0];
                REG_PULSE:       cfg_reg.pulse       <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg  <= s_now_ms;
            temp_reg <= s_temperature;
        end
    end

    tpvc_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .now_ms      (now_reg),
        .temperature (temp_reg),
        .nxt         (state_next)
    );

    // Controller state: update once per request leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= ST_HOMING;
            state_reg.pins        <= PINS_HOLD;
            state_reg.pos         <= TRAVEL_RESET;
            state_reg.last_tick   <= '0;
            state_reg.last_change <= '0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            open_reg  <= state_next.pins[0];
            close_reg <= state_next.pins[1];
            mode_reg  <= mode_code(state_next.mode);
            pos_reg   <= state_next.pos;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_open_pin_level  = open_reg;
    assign m_close_pin_level = close_reg;
    assign m_mode            = mode_reg;
    assign m_position_ms     = pos_reg;

    // Never drive both actuator pins at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_open_pin_level || m_close_pin_level))
        else $error("both valve pins driven active");

    // An opening result drives only the open pin
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mode == MODE_OPENING) |-> (!m_open_pin_level && m_close_pin_level))
        else $error("opening mode without open drive");

    // A new result only follows a request held in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result without a request");

endmodule
